[hdl/ihp_pkg.sv]
// Shared types and constants of the indexed min-heap.
package ihp_pkg;

  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    KIND_INSERT     = 2'd0,
    KIND_DEL_MIN    = 2'd1,
    KIND_DEL_HANDLE = 2'd2,
    KIND_MODIFY     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_DEAD      = 3'd4
  } status_t;

endpackage

[hdl/ihp_if.sv]
// Request and result channel interfaces of the indexed min-heap.
interface ihp_in_if #(parameter int HW = 13) ();
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic [HW-1:0]                       handle;
  logic signed [ihp_pkg::VALUE_W-1:0]  value;
  modport source (output valid, kind, handle, value, input ready);
  modport sink   (input valid, kind, handle, value, output ready);
endinterface

interface ihp_out_if #(parameter int HW = 13, parameter int CW = 11) ();
  logic                                valid;
  logic                                ready;
  logic [2:0]                          status;
  logic [HW-1:0]                       new_handle;
  logic signed [ihp_pkg::VALUE_W-1:0]  min_value;
  logic [CW-1:0]                       count;
  logic                                is_empty;
  modport source (output valid, status, new_handle, min_value, count, is_empty, input ready);
  modport sink   (input valid, status, new_handle, min_value, count, is_empty, output ready);
endinterface

[hdl/indexed_min_heap.sv]
// Indexed binary min-heap of signed 32-bit values with insertion-ordered handles.
// One request is worked at a time and answers with one result. Heap slots (value and
// handle) live in one RAM and the handle-to-slot map in another, each with one read
// and one write per cycle; the sift walk sets the latency. Insert climbs one heap level
// at a time; delete and modify descend one level at a time (two child reads and a
// compare) and climb instead when the entry moves up. The handle map needs no clearing
// pass: handles above the issued count read as dead. A new request is taken while the
// previous result still waits in the output register.
module indexed_min_heap #(
  parameter int CAPACITY     = 1024,
  parameter int HANDLE_SPACE = 4096,
  localparam int HW  = $clog2(HANDLE_SPACE + 1),
  localparam int CW  = $clog2(CAPACITY + 1),
  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int HAW = (HANDLE_SPACE > 1) ? $clog2(HANDLE_SPACE) : 1
) (
  input  logic  clk,
  input  logic  rst_n,
  ihp_in_if.sink    in_ch,
  ihp_out_if.source out_ch
);

  typedef struct packed {
    logic signed [ihp_pkg::VALUE_W-1:0] value;
    logic [HW-1:0]                      handle;
  } entry_t;

  localparam int SW = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_HREAD, S_RMTOP, S_RMKILL, S_RMLAST, S_DL, S_DLW, S_DRW, S_DCMP,
    S_UCHK, S_UW, S_PLACE, S_FIN, S_FINW, S_OUT
  } state_t;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [HW-1:0]        issued_r;
  logic [CW-1:0]        pos_r;
  entry_t               mv_r, l_r, r_r;
  logic                 has_r_r, moved_r;
  ihp_pkg::kind_t       kind_r;
  logic [HW-1:0]        hnd_r, rm_h_r;
  logic signed [ihp_pkg::VALUE_W-1:0] val_r, min_r;
  ihp_pkg::status_t     status_r;
  logic [HW-1:0]        newh_r;

  logic                 out_valid_r;
  ihp_pkg::status_t     out_status_r;
  logic [HW-1:0]        out_newh_r;
  logic signed [ihp_pkg::VALUE_W-1:0] out_min_r;
  logic [CW-1:0]        out_count_r;

  logic                 s_we, h_we;
  logic [AW-1:0]        s_waddr, s_raddr;
  logic [HAW-1:0]       h_waddr, h_raddr;
  entry_t               s_wdata, s_rdata;
  logic [CW-1:0]        h_wdata, h_rdata;

  logic [CW:0]          child_l, child_r;
  logic                 take_l, take_r;
  logic signed [ihp_pkg::VALUE_W-1:0] best_v;
  entry_t               best_e;
  logic [CW-1:0]        best_pos;
  logic                 accept;

  function automatic logic [HAW-1:0] hidx(input logic [HW-1:0] h);
    logic [HW-1:0] t;
    t = h - 1'b1;
    return t[HAW-1:0];
  endfunction

  function automatic logic [AW-1:0] sidx(input logic [CW:0] s);
    logic [CW:0] t;
    t = s - 1'b1;
    return t[AW-1:0];
  endfunction

  ihp_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slot_ram (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );

  ihp_ram #(.WIDTH(CW), .DEPTH(HANDLE_SPACE)) u_hmap_ram (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
  );

  assign accept  = in_ch.valid && in_ch.ready;
  assign child_l = {pos_r, 1'b0};
  assign child_r = {pos_r, 1'b1};

  // Pick the smaller child, earlier one on ties, against the moving entry.
  always_comb begin
    take_l = l_r.value < mv_r.value;
    best_v = take_l ? l_r.value : mv_r.value;
    take_r = has_r_r && (r_r.value < best_v);
    best_e = take_r ? r_r : l_r;
    best_pos = take_r ? child_r[CW-1:0] : child_l[CW-1:0];
  end

  always_comb begin
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = mv_r;
    s_raddr = '0;
    h_we    = 1'b0;
    h_waddr = '0;
    h_wdata = pos_r;
    h_raddr = hidx(in_ch.handle);
    case (state_r)
      S_RMKILL: begin
        h_we    = 1'b1;
        h_waddr = hidx(rm_h_r);
        h_wdata = '0;
        s_raddr = sidx({1'b0, count_r});
      end
      S_DL: s_raddr = sidx(child_l);
      S_DLW: s_raddr = sidx(child_r);
      S_DCMP: begin
        if (take_l || take_r) begin
          s_we    = 1'b1;
          s_waddr = sidx({1'b0, pos_r});
          s_wdata = best_e;
          h_we    = 1'b1;
          h_waddr = hidx(best_e.handle);
          h_wdata = pos_r;
        end
      end
      S_UCHK: s_raddr = sidx({1'b0, pos_r >> 1});
      S_UW: begin
        if (mv_r.value < s_rdata.value) begin
          s_we    = 1'b1;
          s_waddr = sidx({1'b0, pos_r});
          s_wdata = s_rdata;
          h_we    = 1'b1;
          h_waddr = hidx(s_rdata.handle);
          h_wdata = pos_r;
        end
      end
      S_PLACE: begin
        s_we    = 1'b1;
        s_waddr = sidx({1'b0, pos_r});
        h_we    = 1'b1;
        h_waddr = hidx(mv_r.handle);
      end
      default: ;
    endcase
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.new_handle = out_newh_r;
  assign out_ch.min_value  = out_min_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.is_empty   = (out_count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issued_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself whenever it is free.
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r   <= ihp_pkg::kind_t'(in_ch.kind);
            hnd_r    <= in_ch.handle;
            val_r    <= in_ch.value;
            status_r <= ihp_pkg::ST_OK;
            newh_r   <= '0;
            moved_r  <= 1'b0;
            case (ihp_pkg::kind_t'(in_ch.kind))
              ihp_pkg::KIND_INSERT: begin
                if (count_r >= CW'(CAPACITY)) begin
                  status_r <= ihp_pkg::ST_FULL;
                  state_r  <= S_FIN;
                end else if (issued_r >= HW'(HANDLE_SPACE)) begin
                  status_r <= ihp_pkg::ST_EXHAUSTED;
                  state_r  <= S_FIN;
                end else begin
                  count_r   <= count_r + 1'b1;
                  issued_r  <= issued_r + 1'b1;
                  newh_r    <= issued_r + 1'b1;
                  mv_r      <= '{value: in_ch.value, handle: issued_r + 1'b1};
                  pos_r     <= count_r + 1'b1;
                  state_r   <= S_UCHK;
                end
              end
              ihp_pkg::KIND_DEL_MIN: begin
                if (count_r == '0) begin
                  status_r <= ihp_pkg::ST_EMPTY;
                  state_r  <= S_FIN;
                end else begin
                  pos_r   <= CW'(1);
                  state_r <= S_RMTOP;
                end
              end
              default: begin
                // Handles above the issued count were never written in the map.
                if (in_ch.handle == '0 || in_ch.handle > issued_r) begin
                  status_r <= ihp_pkg::ST_DEAD;
                  state_r  <= S_FIN;
                end else begin
                  state_r <= S_HREAD;
                end
              end
            endcase
          end
        end
        S_HREAD: begin
          if (h_rdata == '0 || h_rdata > count_r) begin
            status_r <= ihp_pkg::ST_DEAD;
            state_r  <= S_FIN;
          end else begin
            pos_r <= h_rdata;
            if (kind_r == ihp_pkg::KIND_DEL_HANDLE) begin
              rm_h_r  <= hnd_r;
              state_r <= S_RMKILL;
            end else begin
              mv_r    <= '{value: val_r, handle: hnd_r};
              state_r <= S_DL;
            end
          end
        end
        S_RMTOP: begin
          rm_h_r  <= s_rdata.handle;
          state_r <= S_RMKILL;
        end
        S_RMKILL: state_r <= S_RMLAST;
        S_RMLAST: begin
          // The last entry fills the hole; drop it outright if it was the victim.
          mv_r    <= s_rdata;
          count_r <= count_r - 1'b1;
          state_r <= (pos_r == count_r) ? S_FIN : S_DL;
        end
        S_DL: begin
          if (child_l > {1'b0, count_r}) begin
            state_r <= moved_r ? S_PLACE : S_UCHK;
          end else begin
            state_r <= S_DLW;
          end
        end
        S_DLW: begin
          l_r <= s_rdata;
          if (child_r <= {1'b0, count_r}) begin
            state_r <= S_DRW;
          end else begin
            has_r_r <= 1'b0;
            state_r <= S_DCMP;
          end
        end
        S_DRW: begin
          r_r     <= s_rdata;
          has_r_r <= 1'b1;
          state_r <= S_DCMP;
        end
        S_DCMP: begin
          if (take_l || take_r) begin
            pos_r   <= best_pos;
            moved_r <= 1'b1;
            state_r <= S_DL;
          end else begin
            state_r <= moved_r ? S_PLACE : S_UCHK;
          end
        end
        S_UCHK: state_r <= (pos_r == CW'(1)) ? S_PLACE : S_UW;
        S_UW: begin
          if (mv_r.value < s_rdata.value) begin
            pos_r   <= pos_r >> 1;
            state_r <= S_UCHK;
          end else begin
            state_r <= S_PLACE;
          end
        end
        S_PLACE: state_r <= S_FIN;
        S_FIN: begin
          if (count_r == '0) begin
            min_r   <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_FINW;
          end
        end
        S_FINW: begin
          min_r   <= s_rdata.value;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_newh_r   <= newh_r;
            out_min_r    <= min_r;
            out_count_r  <= count_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("entry count above capacity");

  a_issued_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> issued_r >= $past(issued_r)) else $error("handle counter went back");

  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_count_r == '0 |-> out_min_r == '0) else $error("empty heap shows a minimum");

  a_newh_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_newh_r != '0 |-> out_status_r == ihp_pkg::ST_OK)
    else $error("handle given on a failed request");
`endif

endmodule

[hdl/ihp_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module ihp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
